### src/dhd_pkg.sv
package dhd_pkg;

   localparam int TABLE_SIZE  = 1021;
   localparam int MAX_LETTERS = 12;

   localparam int KEY_W     = 28;
   localparam int SLOT_W    = $clog2(TABLE_SIZE);
   localparam int PROBE_W   = $clog2(TABLE_SIZE + 1);
   localparam int RED_W     = SLOT_W + 3;
   localparam int LEN_W     = 4;
   localparam int LETTERS_W = 2 * MAX_LETTERS;

   localparam logic [LEN_W-1:0]   MAX_LEN       = LEN_W'(MAX_LETTERS);
   localparam logic [RED_W-1:0]   POS_MODULUS   = RED_W'(TABLE_SIZE);
   localparam logic [RED_W-1:0]   STEP_MODULUS  = RED_W'(TABLE_SIZE - 1);
   localparam logic [SLOT_W-1:0]  LAST_SLOT     = SLOT_W'(TABLE_SIZE - 1);
   localparam logic [PROBE_W-1:0] PROBE_LIMIT   = PROBE_W'(TABLE_SIZE);

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] pos;
      logic [SLOT_W-1:0] stride;
   } key_result_type;

   // Reduces a value below five times the modulus to its remainder.
   function automatic logic [SLOT_W-1:0] mod_reduce(input logic [RED_W-1:0] value,
                                                   input logic [RED_W-1:0] modulus);
      logic [RED_W-1:0] rest;
      rest = value;
      if (rest >= (modulus << 2)) begin
         rest = rest - (modulus << 2);
      end
      if (rest >= (modulus << 1)) begin
         rest = rest - (modulus << 1);
      end
      if (rest >= modulus) begin
         rest = rest - modulus;
      end
      return rest[SLOT_W-1:0];
   endfunction

endpackage

### src/dhd_if.sv
interface dhd_req_if import dhd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [LEN_W-1:0]     word_length;
   logic [LETTERS_W-1:0] word_letters;

   modport source(output valid, output mode, output word_length, output word_letters,
                  input ready);
   modport sink(input valid, input mode, input word_length, input word_letters,
                output ready);
endinterface

interface dhd_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic inserted;
   logic table_full;

   modport source(output valid, output found, output inserted, output table_full,
                  input ready);
   modport sink(input valid, input found, input inserted, input table_full,
                output ready);
endinterface

### src/dhd_key_unit.sv
module dhd_key_unit import dhd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [LEN_W-1:0]     word_length,
   input  logic [LETTERS_W-1:0] word_letters,
   output logic                 done,
   output key_result_type       result
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [LEN_W-1:0]     left_ff, left_in;
   logic [LETTERS_W-1:0] shift_ff, shift_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [SLOT_W-1:0]    pos_ff, pos_in;
   logic [SLOT_W-1:0]    step_ff, step_in;
   logic [LEN_W-1:0]     count;
   logic [2:0]           digit;

   // Letters are taken from the highest one down, so the key builds up by Horner's rule.
   always_comb begin
      count = word_length;
      if (word_length == '0) begin
         count = LEN_W'(1);
      end else if (word_length > MAX_LEN) begin
         count = MAX_LEN;
      end
      digit = {1'b0, shift_ff[LETTERS_W-1 -: 2]} + 3'd1;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      left_in  = left_ff;
      shift_in = shift_ff;
      key_in   = key_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;

      if (start) begin
         busy_in  = 1'b1;
         left_in  = count;
         shift_in = word_letters << {MAX_LEN - count, 1'b0};
         key_in   = '0;
         pos_in   = '0;
         step_in  = '0;
      end else if (busy_ff) begin
         key_in   = (key_ff << 2) + key_ff + KEY_W'(digit);
         pos_in   = mod_reduce(RED_W'({pos_ff, 2'b00}) + RED_W'(pos_ff) + RED_W'(digit),
                               POS_MODULUS);
         step_in  = mod_reduce(RED_W'({step_ff, 2'b00}) + RED_W'(step_ff) + RED_W'(digit),
                               STEP_MODULUS);
         shift_in = shift_ff << 2;
         left_in  = left_ff - LEN_W'(1);
         if (left_ff == LEN_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      left_ff  <= left_in;
      shift_ff <= shift_in;
      key_ff   <= key_in;
      pos_ff   <= pos_in;
      step_ff  <= step_in;
   end

   assign done          = done_ff;
   assign result.key    = key_ff;
   assign result.pos    = pos_ff;
   assign result.stride = step_ff + SLOT_W'(1);

endmodule

### src/dhd_slot_ram.sv
module dhd_slot_ram import dhd_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  logic [KEY_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [KEY_W-1:0]  rd_data
);

   logic [KEY_W-1:0] mem [TABLE_SIZE];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/double_hash_dictionary.sv
// Dictionary of DNA words (1 to 12 letters) kept in a 1021-slot open-addressed hash table
// with double hashing. After reset the block clears every table slot and holds req.ready
// low meanwhile. A word is then accepted, its key and both hash values are built letter by
// letter, each probe of the single table read port passes through ST_READ (address) and
// ST_CHECK (compare and possibly write), and the response is posted; a full table takes at
// most 1021 probes. One word is worked on at a time; a pending response word does not block
// the next request.
module double_hash_dictionary import dhd_pkg::*; (
   input logic    clock,
   input logic    reset,
   dhd_req_if.sink   req,
   dhd_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_KEY,
      ST_READ,
      ST_CHECK,
      ST_REPLY
   } state_type;

   state_type            state_ff;
   logic [SLOT_W-1:0]    clear_addr_ff;
   logic                 mode_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [SLOT_W-1:0]    pos_ff;
   logic [SLOT_W-1:0]    stride_ff;
   logic [PROBE_W-1:0]   probes_ff;
   logic                 found_ff, inserted_ff, full_ff;
   logic                 rsp_valid_ff, rsp_found_ff, rsp_inserted_ff, rsp_full_ff;

   logic                 key_start;
   logic                 key_done;
   key_result_type       key_result;
   logic                 ram_wr_en;
   logic [SLOT_W-1:0]    ram_wr_addr;
   logic [KEY_W-1:0]     ram_wr_data;
   logic [KEY_W-1:0]     ram_rd_data;
   logic                 slot_empty;
   logic                 slot_match;
   logic [SLOT_W:0]      pos_sum;
   logic [SLOT_W-1:0]    pos_next;
   logic [PROBE_W-1:0]   probes_in;
   logic                 reply_load;

   dhd_key_unit u_key (
      .clock        (clock),
      .reset        (reset),
      .start        (key_start),
      .word_length  (req.word_length),
      .word_letters (req.word_letters),
      .done         (key_done),
      .result       (key_result)
   );

   dhd_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   assign req.ready  = (state_ff == ST_IDLE);
   assign key_start  = req.valid && req.ready;

   assign slot_empty = (ram_rd_data == '0);
   assign slot_match = (ram_rd_data == key_ff);

   assign reply_load = (state_ff == ST_REPLY) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff;
      ram_wr_data = key_ff;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = '0;
      end else if (state_ff == ST_CHECK && mode_ff && slot_empty) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      pos_sum  = {1'b0, pos_ff} + {1'b0, stride_ff};
      pos_next = pos_sum[SLOT_W-1:0];
      if (pos_sum >= (SLOT_W + 1)'(TABLE_SIZE)) begin
         pos_next = SLOT_W'(pos_sum - (SLOT_W + 1)'(TABLE_SIZE));
      end
      probes_in = probes_ff + PROBE_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (reply_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clear_addr_ff <= clear_addr_ff + SLOT_W'(1);
               if (clear_addr_ff == LAST_SLOT) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (key_start) begin
                  mode_ff  <= req.mode;
                  state_ff <= ST_KEY;
               end
            end
            ST_KEY: begin
               if (key_done) begin
                  key_ff    <= key_result.key;
                  pos_ff    <= key_result.pos;
                  stride_ff <= key_result.stride;
                  probes_ff <= '0;
                  state_ff  <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (slot_empty) begin
                  found_ff    <= 1'b0;
                  inserted_ff <= mode_ff;
                  full_ff     <= 1'b0;
                  state_ff    <= ST_REPLY;
               end else if (!mode_ff && slot_match) begin
                  found_ff    <= 1'b1;
                  inserted_ff <= 1'b0;
                  full_ff     <= 1'b0;
                  state_ff    <= ST_REPLY;
               end else if (probes_in == PROBE_LIMIT) begin
                  found_ff    <= 1'b0;
                  inserted_ff <= 1'b0;
                  full_ff     <= 1'b1;
                  state_ff    <= ST_REPLY;
               end else begin
                  probes_ff <= probes_in;
                  pos_ff    <= pos_next;
                  state_ff  <= ST_READ;
               end
            end
            ST_REPLY: begin
               if (reply_load) begin
                  rsp_found_ff    <= found_ff;
                  rsp_inserted_ff <= inserted_ff;
                  rsp_full_ff     <= full_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.inserted   = rsp_inserted_ff;
   assign rsp.table_full = rsp_full_ff;

endmodule
